// File: rtl/bitmap_slot_allocator_chained_macros.svh
// ----------------------------------------------------------------------------
// Bitmap slot allocator: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_CHAINED_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_CHAINED_MACROS_SVH

// same-cycle implication
`define BSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap slot allocator check failed");

// next-cycle implication
`define BSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap slot allocator check failed");

`endif

// File: rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Sizes, status codes and the types shared by the allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsa_pkg;

    localparam int SLOTS     = 1024;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = SLOT_W + 1;
    localparam int ROW_BITS  = 32;
    localparam int ROW_W     = $clog2(ROW_BITS);
    localparam int ROWS      = SLOTS / ROW_BITS;
    localparam int ROWADDR_W = $clog2(ROWS);

    localparam logic [CNT_W-1:0] END_MARK = CNT_W'(SLOTS);

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    typedef struct packed {
        logic              func;
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] start_slot;
    } req_t;

    typedef struct packed {
        logic [CNT_W-1:0]  granted;
        logic [SLOT_W-1:0] head_slot;
        logic [1:0]        status;
        logic [CNT_W-1:0]  used_after;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic start_scan;
        logic rd;
        logic grant;
        logic skip;
        logic clear;
        logic set_full;
        logic set_bad;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic func;
        logic full;
        logic count_zero;
        logic found;
        logic last;
        logic bit_used;
        logic link_end;
        logic link_bad;
    } sts_t;

endpackage

// File: rtl/bitmap_slot_allocator_chained.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator, next-fit with chained grants
// Allocates slots from a used-bitmap and frees them by walking their chain.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req): one request per beat, either an
//   allocate of req.count slots or a free of the chain headed by
//   req.start_slot. req_stall is high while a request is in progress.
//   rsp channel (rsp_valid/rsp_stall/rsp): one result beat per request.
//   Requests are handled one at a time. Each step is one registered read
//   of the bitmap row and link memories, followed by a write-back when a
//   slot is granted or freed. An allocate takes one step per grant and per
//   skipped bitmap row with no free slot, a free one per slot walked.
//   Allocate of zero slots or into a full store answers without a scan.
//   The result sits in an output register, so a new request is taken while
//   a stalled result waits; a second finished result waits for that register.
//   Reset clears the used map at once through per-row valid bits (no clearing
//   pass), zeroes the search pointer and the in-use count; the block is ready
//   in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_slot_allocator_chained (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bsa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bsa_pkg::rsp_t rsp
);

    bsa_pkg::cmd_t cmd;
    bsa_pkg::sts_t sts;

    bsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    bsa_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

// File: rtl/bsa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/bsa_dp.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator datapath
// Used-bitmap rows, chain links, scan pointer, counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  bsa_pkg::req_t req,
    input  bsa_pkg::cmd_t cmd,
    output bsa_pkg::sts_t sts,
    output bsa_pkg::rsp_t rsp
);

    logic                             func_reg;
    logic [bsa_pkg::CNT_W-1:0]        count_reg;
    logic [bsa_pkg::SLOT_W-1:0]       cur_reg;
    logic [bsa_pkg::ROWADDR_W-1:0]    row_reg;
    logic                             first_reg;
    logic [bsa_pkg::CNT_W-1:0]        granted_reg;
    logic [bsa_pkg::SLOT_W-1:0]       prev_reg;
    logic [1:0]                       status_reg;
    logic [bsa_pkg::SLOT_W-1:0]       search_reg;
    logic [bsa_pkg::CNT_W-1:0]        used_reg;
    logic [bsa_pkg::ROWS-1:0]         row_valid_reg;
    bsa_pkg::rsp_t                    rsp_reg;

    logic [bsa_pkg::ROWADDR_W-1:0]    row_addr;
    logic [bsa_pkg::ROW_BITS-1:0]     map_rdata;
    logic [bsa_pkg::ROW_BITS-1:0]     map_wdata;
    logic                             map_we;
    logic [bsa_pkg::ROW_BITS-1:0]     row_eff;
    logic [bsa_pkg::ROW_BITS-1:0]     low_mask;
    logic [bsa_pkg::ROW_BITS-1:0]     masked;
    logic [bsa_pkg::ROW_W-1:0]        pos;
    logic [bsa_pkg::ROW_W-1:0]        cur_bit;
    logic [bsa_pkg::SLOT_W-1:0]       grant_idx;
    logic [bsa_pkg::SLOT_W-1:0]       search_next;
    logic [bsa_pkg::ROWADDR_W-1:0]    row_inc;
    logic [bsa_pkg::CNT_W-1:0]        link_rdata;
    logic [bsa_pkg::CNT_W-1:0]        link_wdata;

    assign row_addr = func_reg ? cur_reg[bsa_pkg::SLOT_W-1:bsa_pkg::ROW_W] : row_reg;
    assign row_eff  = row_valid_reg[row_addr] ? map_rdata : '0;
    assign cur_bit  = cur_reg[bsa_pkg::ROW_W-1:0];

    always_comb
    begin
        for (int i = 0; i < bsa_pkg::ROW_BITS; i++)
        begin
            low_mask[i] = (bsa_pkg::ROW_W'(i) < search_reg[bsa_pkg::ROW_W-1:0]);
        end
    end

    assign masked = first_reg ? (row_eff | low_mask) : row_eff;

    // lowest free bit
    always_comb
    begin
        pos = '0;
        for (int i = bsa_pkg::ROW_BITS - 1; i >= 0; i--)
        begin
            if (!masked[i])
            begin
                pos = bsa_pkg::ROW_W'(i);
            end
        end
    end

    assign grant_idx   = {row_reg, pos};
    assign search_next = (grant_idx == bsa_pkg::SLOT_W'(bsa_pkg::SLOTS - 1))
                         ? '0 : grant_idx + 1'b1;
    assign row_inc     = (row_reg == bsa_pkg::ROWADDR_W'(bsa_pkg::ROWS - 1))
                         ? '0 : row_reg + 1'b1;

    assign map_we    = cmd.grant | cmd.clear;
    assign map_wdata = func_reg ? (row_eff & ~(bsa_pkg::ROW_BITS'(1) << cur_bit))
                                : (row_eff |  (bsa_pkg::ROW_BITS'(1) << pos));
    assign link_wdata = (granted_reg == '0) ? bsa_pkg::END_MARK : {1'b0, prev_reg};

    bsa_ram #(
        .WIDTH (bsa_pkg::ROW_BITS),
        .DEPTH (bsa_pkg::ROWS)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (row_addr),
        .wdata (map_wdata),
        .re    (cmd.rd),
        .raddr (row_addr),
        .rdata (map_rdata)
    );

    bsa_ram #(
        .WIDTH (bsa_pkg::CNT_W),
        .DEPTH (bsa_pkg::SLOTS)
    ) u_link (
        .clk   (clk),
        .we    (cmd.grant),
        .waddr (grant_idx),
        .wdata (link_wdata),
        .re    (cmd.rd),
        .raddr (cur_reg),
        .rdata (link_rdata)
    );

    assign sts.func       = func_reg;
    assign sts.full       = (used_reg == bsa_pkg::CNT_W'(bsa_pkg::SLOTS));
    assign sts.count_zero = (count_reg == '0);
    assign sts.found      = ~&masked;
    assign sts.last       = ((granted_reg + bsa_pkg::CNT_W'(1)) == count_reg)
                          || ((used_reg + bsa_pkg::CNT_W'(1)) == bsa_pkg::CNT_W'(bsa_pkg::SLOTS));
    assign sts.bit_used   = row_eff[cur_bit];
    assign sts.link_end   = (link_rdata == bsa_pkg::END_MARK);
    assign sts.link_bad   = (link_rdata > bsa_pkg::END_MARK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_reg    <= '0;
            used_reg      <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            if (cmd.grant)
            begin
                search_reg              <= search_next;
                used_reg                <= used_reg + 1'b1;
                row_valid_reg[row_addr] <= 1'b1;
            end
            else if (cmd.clear)
            begin
                used_reg <= used_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg    <= req.func;
            count_reg   <= req.count;
            cur_reg     <= req.start_slot;
            granted_reg <= '0;
            prev_reg    <= '0;
            status_reg  <= bsa_pkg::ST_OK;
        end
        if (cmd.start_scan)
        begin
            row_reg   <= search_reg[bsa_pkg::SLOT_W-1:bsa_pkg::ROW_W];
            first_reg <= 1'b1;
        end
        if (cmd.grant)
        begin
            granted_reg <= granted_reg + 1'b1;
            prev_reg    <= grant_idx;
            row_reg     <= search_next[bsa_pkg::SLOT_W-1:bsa_pkg::ROW_W];
            first_reg   <= 1'b1;
        end
        if (cmd.skip)
        begin
            row_reg   <= row_inc;
            first_reg <= 1'b0;
        end
        if (cmd.clear)
        begin
            cur_reg <= link_rdata[bsa_pkg::SLOT_W-1:0];
        end
        if (cmd.set_full)
        begin
            status_reg <= bsa_pkg::ST_FULL;
        end
        if (cmd.set_bad)
        begin
            status_reg <= bsa_pkg::ST_NOT_USED;
        end
        if (cmd.load_out)
        begin
            rsp_reg.granted    <= granted_reg;
            rsp_reg.head_slot  <= prev_reg;
            rsp_reg.status     <= status_reg;
            rsp_reg.used_after <= used_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

// File: rtl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator controller
// Sequences allocate scans and free walks, owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    input  bsa_pkg::sts_t sts,
    output bsa_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_A_RD   = 3'd2;
    localparam logic [2:0] S_A_CHK  = 3'd3;
    localparam logic [2:0] S_F_RD   = 3'd4;
    localparam logic [2:0] S_F_CHK  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.func)
                begin
                    state_next = S_F_RD;
                end
                else if (sts.full)
                begin
                    cmd.set_full = 1'b1;
                    state_next   = S_FIN;
                end
                else if (sts.count_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = S_A_RD;
                end
            end
            S_A_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (sts.found)
                begin
                    cmd.grant  = 1'b1;
                    state_next = sts.last ? S_FIN : S_A_RD;
                end
                else
                begin
                    cmd.skip   = 1'b1;
                    state_next = S_A_RD;
                end
            end
            S_F_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (!sts.bit_used)
                begin
                    cmd.set_bad = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.clear = 1'b1;
                    if (sts.link_end)
                    begin
                        state_next = S_FIN;
                    end
                    else if (sts.link_bad)
                    begin
                        cmd.set_bad = 1'b1;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_F_RD;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// File: rtl/bsa_checker.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator port checker
// Port-level checks on the request and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "bitmap_slot_allocator_chained_macros.svh"

module bsa_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input bsa_pkg::rsp_t rsp
);

    `BSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `BSA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
    `BSA_ASSERT_NOW(a_used_range, rsp_valid, rsp.used_after <= bsa_pkg::CNT_W'(bsa_pkg::SLOTS))
    `BSA_ASSERT_NOW(a_full_result, rsp_valid && rsp.status == bsa_pkg::ST_FULL, rsp.granted == '0 && rsp.used_after == bsa_pkg::CNT_W'(bsa_pkg::SLOTS))

endmodule

bind bitmap_slot_allocator_chained bsa_checker u_bsa_checker (.*);
